[design/uvs_pkg.sv]
package uvs_pkg;

  localparam int MAX_SEGMENTS_DEF = 256;
  localparam int FRAC_BITS_DEF    = 16;
  localparam int MIN_SEGMENTS     = 3;

  localparam int IDX_W      = 8;
  localparam int RAD_W      = 24;
  localparam int SEG_W      = 9;
  localparam int COORD_W    = 25;
  localparam int SLOT_W     = 3;
  localparam int ANG_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam int QB         = 30;
  localparam int DVD_W      = IDX_W + 1 + ANG_W;
  localparam int SC_LAT     = 19;

  localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEGMENTS = 2'd1;

  localparam logic [RAD_W-1:0] RADIUS_RST   = 24'd65536;
  localparam logic [SEG_W-1:0] SEGMENTS_RST = 9'd16;

  localparam logic [SLOT_W-1:0] SLOT_FIRST = 3'd0;
  localparam logic [SLOT_W-1:0] SLOT_LAST  = 3'd5;

  // column and row offset of each output corner, bit k for slot k
  localparam logic [5:0] DCOL_MAP = 6'b101100;
  localparam logic [5:0] DROW_MAP = 6'b110010;

  localparam logic [32:0] TWO_PI_Q30 = 33'd6746518852;
  localparam logic [30:0] Q30_ONE    = 31'h4000_0000;
  localparam logic [61:0] Q30_HALF   = 62'h2000_0000;

  typedef struct packed {
    logic [1:0]  quad;
    logic        swap;
    logic [29:0] x;
    logic [29:0] x2;
  } sc_side_t;

  function automatic logic [30:0] abs_q30(logic signed [31:0] v);
    logic [31:0] n;
    n = -v;
    return v[31] ? n[30:0] : v[30:0];
  endfunction

endpackage

[design/uvs_if.sv]
interface uvs_cell_if import uvs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] cell_col;
  logic [IDX_W-1:0] cell_row;

  modport source (output valid, cell_col, cell_row, input ready);
  modport sink   (input valid, cell_col, cell_row, output ready);
endinterface

interface uvs_vert_if import uvs_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] vert_x;
  logic signed [COORD_W-1:0] vert_y;
  logic signed [COORD_W-1:0] vert_z;
  logic [SLOT_W-1:0]         corner_slot;
  logic                      last_vertex;

  modport source (output valid, vert_x, vert_y, vert_z, corner_slot, last_vertex,
                  input ready);
  modport sink   (input valid, vert_x, vert_y, vert_z, corner_slot, last_vertex,
                  output ready);
endinterface

interface uvs_cfg_if import uvs_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[design/uvs_div_cell.sv]
module uvs_div_cell #(
  parameter int DVD_W = 41,
  parameter int DV_W  = 10,
  parameter int QUO_W = 32
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [DV_W-1:0]  dv_i,
  input  logic [DV_W-1:0]  rem_i,
  input  logic [DVD_W-1:0] dvd_i,
  input  logic [QUO_W-1:0] quo_i,
  output logic [DV_W-1:0]  rem_o,
  output logic [DVD_W-1:0] dvd_o,
  output logic [QUO_W-1:0] quo_o
);

  logic [DV_W:0]  trial;
  logic [DV_W:0]  diff;
  logic           ge;

  assign trial = {rem_i, dvd_i[DVD_W-1]};
  assign ge    = trial >= {1'b0, dv_i};
  assign diff  = trial - {1'b0, dv_i};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o <= ge ? diff[DV_W-1:0] : trial[DV_W-1:0];
      dvd_o <= {dvd_i[DVD_W-2:0], 1'b0};
      quo_o <= {quo_i[QUO_W-2:0], ge};
    end
  end

endmodule

[design/uvs_sincos.sv]
module uvs_sincos import uvs_pkg::*; (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic [ANG_W-1:0]        ang_i,
  output logic signed [31:0]      sin_o,
  output logic signed [31:0]      cos_o
);

  localparam int          STEPS = 5;
  localparam int          KS [STEPS] = '{72, 42, 20, 6, 1};
  localparam int          KC [STEPS] = '{90, 56, 30, 12, 2};
  localparam logic [63:0] TWO32 = 64'd1 << 32;

  logic [1:0]  quad0_q, quad1_q;
  logic        swap0_q, swap1_q;
  logic [29:0] rr_q, x1_q;
  logic [29:0] r_w;
  logic        swap_w;
  logic [62:0] xm_w;
  logic [59:0] x2m_w;

  sc_side_t    side_q [0:3*STEPS];
  logic [30:0] acc_s_q [STEPS];
  logic [30:0] acc_c_q [STEPS];

  assign r_w    = ang_i[29:0];
  assign swap_w = r_w > 30'h2000_0000;
  assign xm_w   = {33'd0, rr_q} * {30'd0, TWO_PI_Q30};
  assign x2m_w  = {30'd0, x1_q} * {30'd0, x1_q};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quad0_q <= ang_i[31:30];
      swap0_q <= swap_w;
      rr_q    <= swap_w ? (Q30_ONE[29:0] - r_w) : r_w;
      quad1_q <= quad0_q;
      swap1_q <= swap0_q;
      x1_q    <= xm_w[61:32];
      side_q[0] <= '{quad: quad1_q, swap: swap1_q, x: x1_q, x2: x2m_w[59:30]};
    end
  end

  for (genvar t = 0; t < STEPS; t++) begin : g_step
    localparam logic [31:0] RS = 32'(TWO32 / KS[t]);
    localparam logic [31:0] RC = 32'(TWO32 / KC[t]);

    logic [30:0] acc_s_in, acc_c_in;
    logic [60:0] ms_w, mc_w;
    logic [29:0] pa_s_q, pa_c_q, pb_s_q, pb_c_q, q0_s_q, q0_c_q;
    logic [61:0] qs_w, qc_w;
    logic [30:0] rs_w, rc_w, ts_w, tc_w;
    logic [29:0] fs_w, fc_w;

    assign acc_s_in = (t == 0) ? Q30_ONE : acc_s_q[(t == 0) ? 0 : t - 1];
    assign acc_c_in = (t == 0) ? Q30_ONE : acc_c_q[(t == 0) ? 0 : t - 1];

    assign ms_w = (t == STEPS - 1) ? ({31'd0, side_q[3*t].x} * {30'd0, acc_s_in})
                                   : ({31'd0, side_q[3*t].x2} * {30'd0, acc_s_in});
    assign mc_w = {31'd0, side_q[3*t].x2} * {30'd0, acc_c_in};

    assign qs_w = {32'd0, pa_s_q} * {30'd0, RS};
    assign qc_w = {32'd0, pa_c_q} * {30'd0, RC};

    assign ts_w = {1'b0, q0_s_q} * 31'(KS[t]);
    assign tc_w = {1'b0, q0_c_q} * 31'(KC[t]);
    assign rs_w = {1'b0, pb_s_q} - ts_w;
    assign rc_w = {1'b0, pb_c_q} - tc_w;
    assign fs_w = q0_s_q + 30'(rs_w >= 31'(KS[t]));
    assign fc_w = q0_c_q + 30'(rc_w >= 31'(KC[t]));

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[3*t+1] <= side_q[3*t];
        side_q[3*t+2] <= side_q[3*t+1];
        side_q[3*t+3] <= side_q[3*t+2];
        pa_s_q <= ms_w[59:30];
        pa_c_q <= mc_w[59:30];
        pb_s_q <= pa_s_q;
        pb_c_q <= pa_c_q;
        q0_s_q <= qs_w[61:32];
        q0_c_q <= qc_w[61:32];
        acc_c_q[t] <= Q30_ONE - {1'b0, fc_w};
        if (t == STEPS - 1) begin
          acc_s_q[t] <= {1'b0, pb_s_q};
        end else begin
          acc_s_q[t] <= Q30_ONE - {1'b0, fs_w};
        end
      end
    end
  end

  logic        [30:0] sq_w, cq_w;
  logic signed [31:0] sp_w, cp_w;
  sc_side_t           fin_w;

  assign fin_w = side_q[3*STEPS];
  assign sq_w  = fin_w.swap ? acc_c_q[STEPS-1] : acc_s_q[STEPS-1];
  assign cq_w  = fin_w.swap ? acc_s_q[STEPS-1] : acc_c_q[STEPS-1];
  assign sp_w  = signed'({1'b0, sq_w});
  assign cp_w  = signed'({1'b0, cq_w});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      case (fin_w.quad)
        2'd0: begin
          sin_o <= sp_w;
          cos_o <= cp_w;
        end
        2'd1: begin
          sin_o <= cp_w;
          cos_o <= -sp_w;
        end
        2'd2: begin
          sin_o <= -sp_w;
          cos_o <= -cp_w;
        end
        default: begin
          sin_o <= -cp_w;
          cos_o <= sp_w;
        end
      endcase
    end
  end

endmodule

[design/uv_sphere_triangle_generator.sv]
// Takes one grid cell (column, row) per input word and returns the six vertices of its two
// triangles in the order top-left, bottom-left, top-right, top-right, bottom-left,
// bottom-right, one vertex word per cycle while the output is not stalled; the next cell
// is taken as the last vertex of the current one enters the pipeline, so the sustained
// rate is set by the single vertex output port. Each vertex runs through a 41-cell restoring
// divider chain for its two angles, a 19-stage sine and cosine pipeline and four scaling
// stages before it reaches the output. A stalled output freezes the whole pipeline. Radius
// and segment count are read directly by the pipeline and may only be written while no vertex is in flight.
module uv_sphere_triangle_generator import uvs_pkg::*; #(
  parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
  parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  uvs_cell_if.sink   cell_i,
  uvs_vert_if.source vert_o,
  uvs_cfg_if.sink    cfg_i
);

  localparam int              NW      = $clog2(MAX_SEGMENTS + 1);
  localparam int              DV_W    = NW + 1;
  localparam int              MUL_LAT = 4;
  localparam int              LAT     = DVD_W + SC_LAT + MUL_LAT;
  localparam logic [RAD_W-1:0] MIN_RAD = RAD_W'(((1 << FRAC_BITS) + 999) / 1000);

  logic [RAD_W-1:0] radius_q;
  logic [SEG_W-1:0] segments_q;
  logic [RAD_W-1:0] rad_eff;
  logic [NW-1:0]    n_eff;
  logic [31:0]      seg_ext;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q   <= RADIUS_RST;
      segments_q <= SEGMENTS_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_RADIUS:   radius_q   <= cfg_i.data[RAD_W-1:0];
        REG_SEGMENTS: segments_q <= cfg_i.data[SEG_W-1:0];
        default: ;
      endcase
    end
  end

  assign seg_ext = 32'(segments_q);
  assign n_eff   = (seg_ext < 32'(MIN_SEGMENTS)) ? NW'(MIN_SEGMENTS) :
                   (seg_ext > 32'(MAX_SEGMENTS)) ? NW'(MAX_SEGMENTS) : NW'(seg_ext);
  assign rad_eff = (radius_q < MIN_RAD) ? MIN_RAD : radius_q;

  // cell sequencer
  logic             adv;
  logic             busy_q;
  logic [SLOT_W-1:0] slot_q;
  logic [IDX_W-1:0] col_q, row_q;
  logic             accept;

  assign adv          = !vert_o.valid || vert_o.ready;
  assign cell_i.ready = adv && (!busy_q || slot_q == SLOT_LAST);
  assign accept       = cell_i.valid && cell_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      slot_q <= SLOT_FIRST;
    end else if (accept) begin
      busy_q <= 1'b1;
      slot_q <= SLOT_FIRST;
    end else if (adv && busy_q) begin
      if (slot_q == SLOT_LAST) begin
        busy_q <= 1'b0;
      end else begin
        slot_q <= slot_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      col_q <= cell_i.cell_col;
      row_q <= cell_i.cell_row;
    end
  end

  // angle dividers
  logic [IDX_W:0]   i_ent, j_ent;
  logic [DV_W-1:0]  dv_th, dv_ph;
  logic [DV_W-1:0]  th_rem [0:DVD_W];
  logic [DVD_W-1:0] th_dvd [0:DVD_W];
  logic [ANG_W-1:0] th_quo [0:DVD_W];
  logic [DV_W-1:0]  ph_rem [0:DVD_W];
  logic [DVD_W-1:0] ph_dvd [0:DVD_W];
  logic [ANG_W-1:0] ph_quo [0:DVD_W];

  assign i_ent = {1'b0, col_q} + (IDX_W + 1)'(DCOL_MAP[slot_q]);
  assign j_ent = {1'b0, row_q} + (IDX_W + 1)'(DROW_MAP[slot_q]);
  assign dv_th = DV_W'(n_eff);
  assign dv_ph = {n_eff, 1'b0};

  assign th_rem[0] = '0;
  assign th_quo[0] = '0;
  assign th_dvd[0] = {i_ent, ANG_W'(n_eff >> 1)};
  assign ph_rem[0] = '0;
  assign ph_quo[0] = '0;
  assign ph_dvd[0] = {j_ent, ANG_W'(n_eff)};

  for (genvar k = 0; k < DVD_W; k++) begin : g_div
    uvs_div_cell #(.DVD_W(DVD_W), .DV_W(DV_W), .QUO_W(ANG_W)) u_th (
      .clk_i (clk_i),
      .en_i  (adv),
      .dv_i  (dv_th),
      .rem_i (th_rem[k]),
      .dvd_i (th_dvd[k]),
      .quo_i (th_quo[k]),
      .rem_o (th_rem[k+1]),
      .dvd_o (th_dvd[k+1]),
      .quo_o (th_quo[k+1])
    );
    uvs_div_cell #(.DVD_W(DVD_W), .DV_W(DV_W), .QUO_W(ANG_W)) u_ph (
      .clk_i (clk_i),
      .en_i  (adv),
      .dv_i  (dv_ph),
      .rem_i (ph_rem[k]),
      .dvd_i (ph_dvd[k]),
      .quo_i (ph_quo[k]),
      .rem_o (ph_rem[k+1]),
      .dvd_o (ph_dvd[k+1]),
      .quo_o (ph_quo[k+1])
    );
  end

  // sine and cosine
  logic signed [31:0] st, ct, sp, cp;

  uvs_sincos u_sc_th (
    .clk_i (clk_i),
    .en_i  (adv),
    .ang_i (th_quo[DVD_W]),
    .sin_o (st),
    .cos_o (ct)
  );

  uvs_sincos u_sc_ph (
    .clk_i (clk_i),
    .en_i  (adv),
    .ang_i (ph_quo[DVD_W]),
    .sin_o (sp),
    .cos_o (cp)
  );

  // scaling
  logic [61:0] ax_q, az_q;
  logic        nx1_q, nz1_q, ny1_q, nx2_q, nz2_q, ny2_q, nx3_q, nz3_q, ny3_q;
  logic [30:0] cpm1_q, cpm2_q, fx_q, fz_q;
  logic [61:0] fx_w, fz_w;
  logic [54:0] px_q, py_q, pz_q;
  logic [54:0] rx_w, ry_w, rz_w;
  logic [COORD_W-1:0] mx_w, my_w, mz_w;
  logic signed [COORD_W-1:0] x_q, y_q, z_q;

  assign fx_w = ax_q + Q30_HALF;
  assign fz_w = az_q + Q30_HALF;
  assign rx_w = px_q + 55'(Q30_HALF);
  assign ry_w = py_q + 55'(Q30_HALF);
  assign rz_w = pz_q + 55'(Q30_HALF);
  assign mx_w = {1'b0, rx_w[53:30]};
  assign my_w = {1'b0, ry_w[53:30]};
  assign mz_w = {1'b0, rz_w[53:30]};

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ax_q   <= {31'd0, abs_q30(sp)} * {31'd0, abs_q30(ct)};
      az_q   <= {31'd0, abs_q30(sp)} * {31'd0, abs_q30(st)};
      nx1_q  <= sp[31] ^ ct[31];
      nz1_q  <= sp[31] ^ st[31];
      ny1_q  <= cp[31];
      cpm1_q <= abs_q30(cp);
      fx_q   <= fx_w[60:30];
      fz_q   <= fz_w[60:30];
      cpm2_q <= cpm1_q;
      nx2_q  <= nx1_q;
      nz2_q  <= nz1_q;
      ny2_q  <= ny1_q;
      px_q   <= {31'd0, rad_eff} * {24'd0, fx_q};
      py_q   <= {31'd0, rad_eff} * {24'd0, cpm2_q};
      pz_q   <= {31'd0, rad_eff} * {24'd0, fz_q};
      nx3_q  <= nx2_q;
      nz3_q  <= nz2_q;
      ny3_q  <= ny2_q;
      x_q    <= nx3_q ? -signed'(mx_w) : signed'(mx_w);
      y_q    <= ny3_q ? -signed'(my_w) : signed'(my_w);
      z_q    <= nz3_q ? -signed'(mz_w) : signed'(mz_w);
    end
  end

  // word valid and slot alongside the datapath
  logic              vld_q  [LAT];
  logic [SLOT_W-1:0] slotp_q [LAT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < LAT; s++) begin
        vld_q[s] <= 1'b0;
      end
    end else if (adv) begin
      vld_q[0] <= busy_q;
      for (int s = 1; s < LAT; s++) begin
        vld_q[s] <= vld_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      slotp_q[0] <= slot_q;
      for (int s = 1; s < LAT; s++) begin
        slotp_q[s] <= slotp_q[s-1];
      end
    end
  end

  assign vert_o.valid       = vld_q[LAT-1];
  assign vert_o.vert_x      = x_q;
  assign vert_o.vert_y      = y_q;
  assign vert_o.vert_z      = z_q;
  assign vert_o.corner_slot = slotp_q[LAT-1];
  assign vert_o.last_vertex = slotp_q[LAT-1] == SLOT_LAST;

endmodule

[design/uvs_checker.sv]
module uvs_checker import uvs_pkg::*; (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      vert_valid_i,
  input logic                      vert_ready_i,
  input logic signed [COORD_W-1:0] vert_x_i,
  input logic signed [COORD_W-1:0] vert_y_i,
  input logic signed [COORD_W-1:0] vert_z_i,
  input logic [SLOT_W-1:0]         corner_slot_i,
  input logic                      last_vertex_i
);

  logic [SLOT_W-1:0] exp_slot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_slot_q <= SLOT_FIRST;
    end else if (vert_valid_i && vert_ready_i) begin
      exp_slot_q <= (corner_slot_i == SLOT_LAST) ? SLOT_FIRST : corner_slot_i + 1'b1;
    end
  end

  a_slot_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vert_valid_i |-> corner_slot_i == exp_slot_q)
    else $error("vertex word out of corner order");

  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vert_valid_i |-> last_vertex_i == (corner_slot_i == SLOT_LAST))
    else $error("last vertex flag does not match corner slot");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vert_valid_i && !vert_ready_i |=> vert_valid_i && $stable(vert_x_i)
      && $stable(vert_y_i) && $stable(vert_z_i) && $stable(corner_slot_i))
    else $error("stalled vertex word changed");

endmodule

bind uv_sphere_triangle_generator uvs_checker u_uvs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .vert_valid_i  (vert_o.valid),
  .vert_ready_i  (vert_o.ready),
  .vert_x_i      (vert_o.vert_x),
  .vert_y_i      (vert_o.vert_y),
  .vert_z_i      (vert_o.vert_z),
  .corner_slot_i (vert_o.corner_slot),
  .last_vertex_i (vert_o.last_vertex)
);
